>>> hw/rtl/rgb565_raster_op_combiner_macros.svh
// ----------------------------------------------------------------------------
// rgb565 raster-op combiner assertion macros
// concurrent check wrappers, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef RGB565_RASTER_OP_COMBINER_MACROS_SVH
`define RGB565_RASTER_OP_COMBINER_MACROS_SVH

`ifndef SYNTHESIS
`define RGBROP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("rgbrop assertion failed");
`define RGBROP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("rgbrop assertion failed");
`else
`define RGBROP_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define RGBROP_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

>>> hw/rtl/rgbrop_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbrop_pkg
// shared types and constants of the rgb565 raster-op combiner
// ----------------------------------------------------------------------------
package rgbrop_pkg;

  localparam int unsigned PIX_W = 16;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [3:0] {
    ROP_COPY        = 4'd0,
    ROP_TRANSPARENT = 4'd1,
    ROP_OR          = 4'd2,
    ROP_XOR         = 4'd3,
    ROP_NOT         = 4'd4,
    ROP_MERGENOT    = 4'd5,
    ROP_ANDNOT      = 4'd6,
    ROP_AND         = 4'd7,
    ROP_GRAY        = 4'd8,
    ROP_REVERSE     = 4'd9
  } rop_mode_t;

  typedef enum logic {
    CFG_ROP_MODE   = 1'b0,
    CFG_KEY_COLOUR = 1'b1
  } cfg_reg_t;

  // luminance weights, unsigned 0.16 fixed point
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // per-stage advance strobes shared with the luma unit
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_adv_t;

endpackage

>>> hw/rtl/rgb565_raster_op_combiner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_raster_op_combiner
// per-pixel raster-operation stage of a 16-bit rgb565 blitter
// ----------------------------------------------------------------------------
// usage:
//   in channel carries one source pixel and the destination pixel under it;
//   out channel returns the new destination pixel and its write enable.
//   rop_mode and key_colour are written on the cfg port while the block is
//   idle; a write takes effect on the next transfer.
// timing:
//   three register stages (products, sum and bitwise result, final select).
//   a result passes through all three and is offered on out from the final
//   select stage; one pixel is taken every clock while out_tready stays high.
//   the luma multiply-add chain sets the stage split.
// reset:
//   rst_n low clears all stage valids and both registers (copy mode, key 0).
// stall:
//   with out_tready low the output stage holds its result; earlier stages
//   keep filling bubbles, and in_tready drops once all three are occupied.
// ----------------------------------------------------------------------------
module rgb565_raster_op_combiner
  import rgbrop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // src_pixel [15:0], dst_pixel [31:16]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_pixel [15:0]
  output logic        out_tuser   // write_enable [0]
);

`include "rgb565_raster_op_combiner_macros.svh"

  rop_mode_t  rop_mode_r;
  pixel_t     key_colour_r;

  logic       v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic       rdy1, rdy2, rdy3;
  stage_adv_t adv;

  pixel_t     src1_r, dst1_r;
  rop_mode_t  mode1_r;
  logic       keyed1_r;

  pixel_t     px2_r, px2_nxt, dst2_r;
  rop_mode_t  mode2_r;
  logic       keyed2_r;

  pixel_t     px3_r, px3_nxt;
  logic       we3_r, we3_nxt;
  logic [5:0] luma;
  pixel_t     gray;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rop_mode_r   <= ROP_COPY;
      key_colour_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROP_MODE:   rop_mode_r   <= rop_mode_t'(cfg_wdata[3:0]);
        CFG_KEY_COLOUR: key_colour_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage flow control
  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign adv.s1    = rdy1;
  assign adv.s2    = rdy2;

  always_comb begin
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    v3_nxt = rdy3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // stage 1: capture, key compare
  always_ff @(posedge clk) begin
    if (rdy1) begin
      src1_r   <= in_tdata[15:0];
      dst1_r   <= in_tdata[31:16];
      mode1_r  <= rop_mode_r;
      keyed1_r <= (in_tdata[15:0] == key_colour_r);
    end
  end

  rgbrop_luma u_luma (
    .clk       (clk),
    .adv       (adv),
    .src_pixel (in_tdata[15:0]),
    .luma      (luma)
  );

  // stage 2: bitwise result
  always_comb begin
    case (mode1_r)
      ROP_OR:       px2_nxt = dst1_r | src1_r;
      ROP_XOR:      px2_nxt = dst1_r ^ src1_r;
      ROP_AND:      px2_nxt = dst1_r & src1_r;
      ROP_NOT:      px2_nxt = ~src1_r;
      ROP_REVERSE:  px2_nxt = ~src1_r;
      ROP_MERGENOT: px2_nxt = dst1_r | ~src1_r;
      ROP_ANDNOT:   px2_nxt = dst1_r & ~src1_r;
      default:      px2_nxt = src1_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      px2_r    <= px2_nxt;
      dst2_r   <= dst1_r;
      mode2_r  <= mode1_r;
      keyed2_r <= keyed1_r;
    end
  end

  // stage 3: gray packing, key skip
  assign gray = (PIX_W'(luma[5:3]) << 11) | (PIX_W'(luma[5:2]) << 5) | PIX_W'(luma[5:3]);

  always_comb begin
    px3_nxt = (mode2_r == ROP_GRAY) ? gray : px2_r;
    we3_nxt = 1'b1;
    if (keyed2_r && (mode2_r inside {ROP_TRANSPARENT, ROP_GRAY, ROP_REVERSE})) begin
      px3_nxt = dst2_r;
      we3_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      px3_r <= px3_nxt;
      we3_r <= we3_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = px3_r;
  assign out_tuser  = we3_r;

  // checks
  `RGBROP_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_tvalid && in_tready, v1_r)
  `RGBROP_ASSERT_NEXT(a_s1_held_on_stall, clk, rst_n, v1_r && !rdy2, v1_r && $stable(src1_r))
  `RGBROP_ASSERT_NEXT(a_s2_moves_to_s3, clk, rst_n, v2_r && rdy3, v3_r)
  `RGBROP_ASSERT_NEXT(a_keyed_skips_write, clk, rst_n,
    v2_r && rdy3 && keyed2_r &&
    (mode2_r == ROP_TRANSPARENT || mode2_r == ROP_GRAY || mode2_r == ROP_REVERSE),
    !out_tuser)

endmodule

>>> hw/rtl/rgbrop_luma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbrop_luma
// two-stage luminance datapath: weighted products, then sum and scale
// ----------------------------------------------------------------------------
module rgbrop_luma
  import rgbrop_pkg::*;
(
  input  logic       clk,
  input  stage_adv_t adv,
  input  pixel_t     src_pixel,
  output logic [5:0] luma
);

  logic [19:0] prod_r_r, prod_r_nxt;
  logic [21:0] prod_g_r, prod_g_nxt;
  logic [17:0] prod_b_r, prod_b_nxt;
  logic [21:0] sum;
  logic [5:0]  luma_r;

  always_comb begin
    prod_r_nxt = 20'(20'(LUMA_WR) * {15'd0, src_pixel[15:11]});
    prod_g_nxt = 22'(22'(LUMA_WG) * {16'd0, src_pixel[10:5]});
    prod_b_nxt = 18'(18'(LUMA_WB) * {13'd0, src_pixel[4:0]});
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      prod_r_r <= prod_r_nxt;
      prod_g_r <= prod_g_nxt;
      prod_b_r <= prod_b_nxt;
    end
  end

  assign sum = {2'd0, prod_r_r} + prod_g_r + {4'd0, prod_b_r};

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      luma_r <= sum[21:16];
    end
  end

  assign luma = luma_r;

endmodule

>>> bench/rgb565_rop_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565 raster-op checker
// Watches the configuration port and both streams of the combiner. For each
// input transfer it works out the new destination pixel and write enable
// from its own copy of the mode and key registers. Each output transfer is
// compared with the oldest pixel still owed.
// ----------------------------------------------------------------------------
module rgb565_rop_checker
  import rgbrop_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // src_pixel [15:0], dst_pixel [31:16]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // out_pixel [15:0]
  input  logic        out_tuser,  // write_enable [0]
  output int          fail_count,
  output int          pending
);

  localparam logic [31:0] WEIGHT_R = 32'd19595;
  localparam logic [31:0] WEIGHT_G = 32'd38470;
  localparam logic [31:0] WEIGHT_B = 32'd7471;

  typedef struct packed {
    pixel_t pixel;
    logic   wr_en;
  } blit_write_t;

  logic [3:0]  mode_q;
  pixel_t      key_q;
  blit_write_t owed_writes[$];
  int          errs = 0;

  function automatic blit_write_t rop_result(logic [3:0] mode, pixel_t key,
                                             pixel_t s, pixel_t d);
    blit_write_t w;
    logic [31:0] y;
    w.wr_en = 1'b1;
    case (mode)
      ROP_TRANSPARENT: w.pixel = s;
      ROP_OR:          w.pixel = d | s;
      ROP_XOR:         w.pixel = d ^ s;
      ROP_NOT:         w.pixel = ~s;
      ROP_MERGENOT:    w.pixel = d | ~s;
      ROP_ANDNOT:      w.pixel = d & ~s;
      ROP_AND:         w.pixel = d & s;
      ROP_GRAY: begin
        y = (WEIGHT_R * 32'(s[15:11]) + WEIGHT_G * 32'(s[10:5])
             + WEIGHT_B * 32'(s[4:0])) >> 16;
        w.pixel = 16'(((y >> 3) << 11) | ((y >> 2) << 5) | (y >> 3));
      end
      ROP_REVERSE:     w.pixel = ~s;
      default:         w.pixel = s;
    endcase
    // keyed source leaves the destination untouched
    if ((s == key) && (mode == ROP_TRANSPARENT || mode == ROP_GRAY ||
                       mode == ROP_REVERSE)) begin
      w.pixel = d;
      w.wr_en = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk) begin
    blit_write_t want;
    if (!rst_n) begin
      mode_q <= ROP_COPY;
      key_q  <= '0;
      owed_writes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_writes.size() == 0) begin
          $error("out transfer with no pixel expected: out_pixel %h", out_tdata);
          errs++;
        end else begin
          want = owed_writes.pop_front();
          if (out_tdata !== want.pixel) begin
            $error("out_pixel: expected %h, actual %h", want.pixel, out_tdata);
            errs++;
          end
          if (out_tuser !== want.wr_en) begin
            $error("write_enable: expected %b, actual %b", want.wr_en, out_tuser);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready)
        owed_writes.push_back(rop_result(mode_q, key_q, in_tdata[15:0], in_tdata[31:16]));
      if (cfg_we) begin
        if (cfg_index == CFG_ROP_MODE) mode_q <= cfg_wdata[3:0];
        else key_q <= cfg_wdata;
      end
    end
    fail_count <= errs;
    pending    <= owed_writes.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565 raster-op combiner testbench
// Drives source and destination pixels through every raster mode, keyed and
// unkeyed, first a directed set and then random blocks under a range of
// mode and key settings, with random gaps on the sender and stalls on the
// receiver plus one long receiver hold. The checker judges every transfer.
// ----------------------------------------------------------------------------
module tb_top;
  import rgbrop_pkg::*;

  localparam logic [3:0] ROP_SPARE_FIRST = 4'd10;
  localparam logic [3:0] ROP_SPARE_LAST  = 4'd15;
  localparam int RANDOM_BLOCKS = 26;
  localparam int BLOCK_PIXELS  = 50;
  localparam int QUIET_BLOCKS  = 3;
  localparam int LONG_HOLD     = 150;
  localparam int HOLD_AFTER    = 400;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = CFG_ROP_MODE;
  logic [15:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  int fail_count;
  int pending;
  int pixels_sent    = 0;
  bit idle_on        = 1'b1;
  bit offering       = 1'b0;
  bit long_hold_done = 1'b0;

  always #10 clk = ~clk;

  rgb565_raster_op_combiner DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rgb565_rop_checker rop_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_pixel(input pixel_t src, input pixel_t dst);
    in_tvalid <= 1'b1;
    in_tdata  <= {dst, src};
    offering = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic settle_pipe();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic load_rop(input logic [3:0] mode, input pixel_t key);
    settle_pipe();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROP_MODE;
    cfg_wdata <= {12'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_KEY_COLOUR;
    cfg_wdata <= key;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: random stalls, one long hold to back the pipe up
  initial begin
    wait (rst_n);
    forever begin
      if (!long_hold_done && pixels_sent >= HOLD_AFTER) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat (idle_on ? $urandom_range(1, 16) : 1) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: copy, key 0
    send_pixel(16'h0000, 16'hffff);
    send_pixel(16'hffff, 16'h0000);

    load_rop(ROP_TRANSPARENT, 16'h1234);
    send_pixel(16'h1234, 16'habcd);
    send_pixel(16'h1235, 16'habcd);
    load_rop(ROP_OR, 16'h0000);
    send_pixel(16'h5555, 16'haaaa);
    load_rop(ROP_XOR, 16'h0000);
    send_pixel(16'hffff, 16'hffff);
    load_rop(ROP_NOT, 16'hffff);
    send_pixel(16'h0000, 16'h1234);
    load_rop(ROP_MERGENOT, 16'h0000);
    send_pixel(16'hf0f0, 16'h0f0f);
    load_rop(ROP_ANDNOT, 16'h0000);
    send_pixel(16'h0f0f, 16'hffff);
    load_rop(ROP_AND, 16'h0000);
    send_pixel(16'ha5a5, 16'hffff);
    load_rop(ROP_GRAY, 16'h0000);
    send_pixel(16'hffff, 16'h0000);
    send_pixel(16'h0000, 16'h5a5a);
    send_pixel(16'h7bef, 16'h0000);
    load_rop(ROP_GRAY, 16'hffff);
    send_pixel(16'hffff, 16'h0001);
    load_rop(ROP_REVERSE, 16'hffff);
    send_pixel(16'hffff, 16'h8000);
    send_pixel(16'h0000, 16'h7fff);
    load_rop(ROP_SPARE_FIRST, 16'h0000);
    send_pixel(16'h1357, 16'h2468);
    load_rop(ROP_SPARE_LAST, 16'h0000);
    send_pixel(16'hfedc, 16'h0123);

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      logic [3:0] mode;
      pixel_t     key;
      pixel_t     src;
      pixel_t     dst;
      if (blk == 0) begin
        mode = ROP_SPARE_LAST;
        key  = 16'hffff;
      end else if (blk == 1) begin
        mode = ROP_COPY;
        key  = 16'h0000;
      end else begin
        case ($urandom_range(0, 2))
          0: mode = ROP_TRANSPARENT;
          1: mode = ($urandom_range(0, 1) == 0) ? ROP_GRAY : ROP_REVERSE;
          default: mode = 4'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: key = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hffff;
          default: key = 16'($urandom);
        endcase
      end
      load_rop(mode, key);
      idle_on = (blk < RANDOM_BLOCKS - QUIET_BLOCKS);
      repeat (BLOCK_PIXELS) begin
        case ($urandom_range(0, 9))
          0, 1, 2: src = key;
          3:       src = 16'h0000;
          4:       src = 16'hffff;
          default: src = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       dst = 16'h0000;
          1:       dst = 16'hffff;
          default: dst = 16'($urandom);
        endcase
        send_pixel(src, dst);
        sender_gap();
      end
    end

    settle_pipe();
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
